[design/symbol_timing_recovery_loop_top_defines.svh]
// Assertion macros for the front end of the symbol timing recovery loop.
`ifndef SYMBOL_TIMING_RECOVERY_LOOP_TOP_DEFINES_SVH
`define SYMBOL_TIMING_RECOVERY_LOOP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define STRL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define STRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/strl_pkg.sv]
// Types and constants shared by the symbol timing recovery loop modules.
package strl_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [19:0] phase_t;
    typedef logic signed [15:0] offset_t;
    typedef logic signed [31:0] error_t;
    typedef logic signed [15:0] gain_t;
    typedef logic signed [20:0] interp_t;

    localparam int SamplesPerSymbol = 4;

    localparam logic signed [20:0] MuOne = 21'sd65536;
    localparam phase_t  InitialPhaseReset = 20'sd11141;
    localparam gain_t   LoopGainReset     = 16'sd655;
    localparam offset_t OffsetMax         = 16'sh7FFF;
    localparam offset_t OffsetMin         = 16'sh8000;

    // Register index as decoded from paddr[2].
    localparam logic RegInitialPhase = 1'b0;
    localparam logic RegLoopGain     = 1'b1;

    // One symbol to work on: the four samples, the wrapped phase and offset.
    typedef struct packed {
        sample_t s0;
        sample_t s1;
        sample_t s2;
        sample_t s3;
        phase_t  mu;
        offset_t off;
    } job_t;

    // New phase handed back from the back end when a symbol completes.
    typedef struct packed {
        logic   valid;
        phase_t mu;
    } commit_t;

    // Phase load from a write of the initial phase register.
    typedef struct packed {
        logic   valid;
        phase_t value;
    } phase_load_t;

endpackage

[design/strl_front.sv]
// Front end: sample taps, counters, phase wrap and symbol detection.
`include "symbol_timing_recovery_loop_top_defines.svh"

module strl_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  strl_pkg::sample_t     sample_value,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  strl_pkg::phase_load_t phase_load,
    input  strl_pkg::commit_t     commit,
    input  logic                  q_ready,
    output logic                  q_push,
    output strl_pkg::job_t        q_job
);

    strl_pkg::phase_t  mu_reg,   mu_next;
    strl_pkg::offset_t off_reg,  off_next;
    logic [31:0]       cnt_reg,  cnt_next;
    logic [31:0]       base_reg, base_next;
    strl_pkg::sample_t tap_reg  [0:2];
    strl_pkg::sample_t tap_next [0:2];
    logic              pend_reg, pend_next;
    logic [1:0]        since_reg, since_next;

    logic signed [20:0] mu_ext;
    strl_pkg::phase_t   mu_wrap;
    strl_pkg::offset_t  off_tent;
    logic [31:0]        due_cnt;
    logic               accept;

    // Tentative wrap of the committed phase into the offset.
    always_comb
    begin
        mu_ext   = {mu_reg[19], mu_reg};
        mu_wrap  = mu_reg;
        off_tent = off_reg;
        if (mu_ext > strl_pkg::MuOne)
        begin
            mu_wrap = 20'(mu_ext - strl_pkg::MuOne);
            if (off_reg != strl_pkg::OffsetMax)
            begin
                off_tent = off_reg + 16'sd1;
            end
        end
        else if (mu_reg[19])
        begin
            mu_wrap = 20'(mu_ext + strl_pkg::MuOne);
            if (off_reg != strl_pkg::OffsetMin)
            begin
                off_tent = off_reg - 16'sd1;
            end
        end
    end

    assign due_cnt = base_reg + {{16{off_tent[15]}}, off_tent} + 32'd3;

    // While a symbol is in flight its new phase is not known yet; symbols are at
    // least three samples apart, so two more samples may enter before waiting.
    assign sample_stall = !q_ready || (pend_reg && (since_reg == 2'd2));
    assign accept       = sample_valid && !sample_stall;
    assign q_push       = accept && !pend_reg && (due_cnt == cnt_reg);

    assign q_job.s0  = tap_reg[2];
    assign q_job.s1  = tap_reg[1];
    assign q_job.s2  = tap_reg[0];
    assign q_job.s3  = sample_value;
    assign q_job.mu  = mu_wrap;
    assign q_job.off = off_tent;

    always_comb
    begin
        mu_next    = mu_reg;
        off_next   = off_reg;
        cnt_next   = cnt_reg;
        base_next  = base_reg;
        tap_next   = tap_reg;
        pend_next  = pend_reg;
        since_next = since_reg;
        if (accept)
        begin
            cnt_next    = cnt_reg + 32'd1;
            tap_next[0] = sample_value;
            tap_next[1] = tap_reg[0];
            tap_next[2] = tap_reg[1];
            if (pend_reg)
            begin
                since_next = since_reg + 2'd1;
            end
        end
        if (q_push)
        begin
            base_next  = base_reg + 32'(strl_pkg::SamplesPerSymbol);
            off_next   = off_tent;
            mu_next    = mu_wrap;
            pend_next  = 1'b1;
            since_next = 2'd0;
        end
        if (commit.valid)
        begin
            mu_next   = commit.mu;
            pend_next = 1'b0;
        end
        if (phase_load.valid)
        begin
            mu_next = phase_load.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg    <= strl_pkg::InitialPhaseReset;
            off_reg   <= '0;
            cnt_reg   <= '0;
            base_reg  <= '0;
            tap_reg   <= '{default: '0};
            pend_reg  <= 1'b0;
            since_reg <= '0;
        end
        else
        begin
            mu_reg    <= mu_next;
            off_reg   <= off_next;
            cnt_reg   <= cnt_next;
            base_reg  <= base_next;
            tap_reg   <= tap_next;
            pend_reg  <= pend_next;
            since_reg <= since_next;
        end
    end

    `STRL_ASSERT_IMPL(a_commit_owned, commit.valid, pend_reg, "commit without a symbol in flight")
    `STRL_ASSERT_NEXT(a_commit_clears, commit.valid, !pend_reg, "symbol still pending after commit")
    `STRL_ASSERT_NEXT(a_no_double, q_push, !q_push, "symbols on consecutive samples")

endmodule

[design/strl_queue.sv]
// Two-entry queue of symbol jobs between the front and back ends.
module strl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  strl_pkg::job_t push_job,
    output logic           ready,
    input  logic           pop,
    output logic           valid,
    output strl_pkg::job_t pop_job
);

    strl_pkg::job_t entry_reg [0:1];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg,  count_next;

    assign ready   = (count_reg != 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/strl_back.sv]
// Back end: interpolation, timing error, averaging, phase update and result register.
module strl_back #(
    parameter int AVERAGE_LENGTH = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  strl_pkg::job_t     q_job,
    output logic               q_pop,
    input  strl_pkg::gain_t    loop_gain,
    output strl_pkg::commit_t  commit,
    output strl_pkg::offset_t  timing_offset,
    output strl_pkg::phase_t   timing_phase,
    output strl_pkg::error_t   timing_error,
    output logic               result_valid,
    input  logic               result_stall
);

    localparam int SlotW     = (AVERAGE_LENGTH > 1) ? $clog2(AVERAGE_LENGTH) : 1;
    localparam int RemW      = SlotW;
    localparam int SumW      = 32 + $clog2(AVERAGE_LENGTH);
    localparam int MagW      = ((SumW + 7) / 8) * 8;
    localparam int DivSteps  = MagW / 8;
    localparam int DivCntW   = (DivSteps > 1) ? $clog2(DivSteps) : 1;
    localparam int LastSlotI = AVERAGE_LENGTH - 1;
    localparam int LastStepI = DivSteps - 1;
    localparam int DivisorI  = AVERAGE_LENGTH;
    localparam logic [RemW:0] Divisor = DivisorI[RemW:0];

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_INTERP = 9'b000000010,
        ST_ERR    = 9'b000000100,
        ST_HIST   = 9'b000001000,
        ST_ABS    = 9'b000010000,
        ST_DIV    = 9'b000100000,
        ST_SIGN   = 9'b001000000,
        ST_GAIN   = 9'b010000000,
        ST_UPD    = 9'b100000000
    } back_state_t;

    back_state_t           state_reg, state_next;
    strl_pkg::job_t        job_reg;
    strl_pkg::interp_t     ip_reg [0:2];
    logic [1:0]            idx_reg,  idx_next;
    strl_pkg::error_t      err_reg;
    logic signed [SumW-1:0] sum_reg, sum_next;
    strl_pkg::error_t      hist_reg [0:AVERAGE_LENGTH-1];
    logic [SlotW-1:0]      slot_reg, slot_next;
    logic [MagW-1:0]       mag_reg,  mag_next;
    logic [RemW-1:0]       rem_reg,  rem_next;
    logic [DivCntW-1:0]    dcnt_reg, dcnt_next;
    logic                  neg_reg;
    strl_pkg::error_t      avg_reg;
    logic signed [47:0]    gprod_reg;
    logic                  out_valid_reg, out_valid_next;
    strl_pkg::offset_t     out_off_reg;
    strl_pkg::phase_t      out_mu_reg;
    strl_pkg::error_t      out_err_reg;

    strl_pkg::sample_t     ia, ib;
    strl_pkg::phase_t      mu_w;
    logic signed [16:0]    idiff;
    logic signed [36:0]    iprod;
    logic [37:0]           iacc;
    strl_pkg::interp_t     ip0, ip1, ip2;
    logic signed [21:0]    ipd;
    logic signed [42:0]    eprod;
    strl_pkg::error_t      err_sat;
    strl_pkg::error_t      old_err;
    logic [SumW-1:0]       sum_abs;
    logic [MagW-1:0]       div_mag;
    logic [RemW-1:0]       div_rem;
    logic [31:0]           quo;
    logic signed [47:0]    gprod;
    logic [47:0]           step_acc;
    strl_pkg::phase_t      step;
    logic signed [21:0]    mu_sum;
    strl_pkg::phase_t      mu_sat;
    logic                  out_free;

    assign mu_w = job_reg.mu;
    assign ip0  = ip_reg[0];
    assign ip1  = ip_reg[1];
    assign ip2  = ip_reg[2];

    // One interpolant per cycle through the shared multiplier, rounded half up.
    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                ia = job_reg.s0;
                ib = job_reg.s1;
            end
            2'd1:
            begin
                ia = job_reg.s1;
                ib = job_reg.s2;
            end
            default:
            begin
                ia = job_reg.s2;
                ib = job_reg.s3;
            end
        endcase
        idiff = 17'(ib) - 17'(ia);
        iprod = mu_w * idiff;
        iacc  = {{6{ia[15]}}, ia, 16'h0000} + {iprod[36], iprod} + 38'd32768;
    end

    // Timing error, saturated to 32 bits.
    always_comb
    begin
        ipd   = 22'(ip2) - 22'(ip0);
        eprod = ipd * ip1;
        if (eprod[42:31] == {12{eprod[42]}})
        begin
            err_sat = eprod[31:0];
        end
        else if (eprod[42])
        begin
            err_sat = 32'sh80000000;
        end
        else
        begin
            err_sat = 32'sh7FFFFFFF;
        end
    end

    // Running sum of the error history and its magnitude.
    assign old_err  = hist_reg[slot_reg];
    assign sum_next = sum_reg - SumW'(old_err) + SumW'(err_reg);
    assign sum_abs  = sum_reg[SumW-1] ? (~sum_reg + 1'b1) : sum_reg;

    // Eight quotient bits a cycle of the restoring division by the average length.
    always_comb
    begin
        logic [RemW:0] part;
        div_mag = mag_reg;
        div_rem = rem_reg;
        for (int b = 0; b < 8; b++)
        begin
            part    = {div_rem, div_mag[MagW-1]};
            div_mag = {div_mag[MagW-2:0], 1'b0};
            if (part >= Divisor)
            begin
                part       = part - Divisor;
                div_mag[0] = 1'b1;
            end
            div_rem = part[RemW-1:0];
        end
    end

    assign quo   = mag_reg[31:0];
    assign gprod = avg_reg * loop_gain;

    // Phase step rounded half up, then the saturated phase.
    always_comb
    begin
        step_acc = gprod_reg + 48'd134217728;
        step     = step_acc[47:28];
        mu_sum   = 22'(mu_w) + 22'(step);
        if (mu_sum[21:19] == {3{mu_sum[21]}})
        begin
            mu_sat = mu_sum[19:0];
        end
        else if (mu_sum[21])
        begin
            mu_sat = 20'sh80000;
        end
        else
        begin
            mu_sat = 20'sh7FFFF;
        end
    end

    assign out_free = !out_valid_reg || !result_stall;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    assign commit.valid = (state_reg == ST_UPD) && out_free;
    assign commit.mu    = mu_sat;

    assign result_valid  = out_valid_reg;
    assign timing_offset = out_off_reg;
    assign timing_phase  = out_mu_reg;
    assign timing_error  = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_INTERP;
                end
            end
            ST_INTERP:
            begin
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd2)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                state_next = ST_HIST;
            end
            ST_HIST:
            begin
                if (slot_reg == LastSlotI[SlotW-1:0])
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                mag_next   = MagW'(sum_abs);
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                mag_next  = div_mag;
                rem_next  = div_rem;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == LastStepI[DivCntW-1:0])
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (state_reg == ST_INTERP)
        begin
            ip_reg[idx_reg] <= iacc[36:16];
        end
        if (state_reg == ST_ERR)
        begin
            err_reg <= err_sat;
        end
        if (state_reg == ST_ABS)
        begin
            neg_reg <= sum_reg[SumW-1];
        end
        if (state_reg == ST_SIGN)
        begin
            avg_reg <= neg_reg ? (~quo + 32'd1) : quo;
        end
        if (state_reg == ST_GAIN)
        begin
            gprod_reg <= gprod;
        end
        if (commit.valid)
        begin
            out_off_reg <= job_reg.off;
            out_mu_reg  <= mu_sat;
            out_err_reg <= err_reg;
        end
        mag_reg <= mag_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < AVERAGE_LENGTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            slot_reg      <= slot_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_HIST)
            begin
                sum_reg            <= sum_next;
                hist_reg[slot_reg] <= err_reg;
            end
        end
    end

endmodule

[design/symbol_timing_recovery_loop_top.sv]
// Top level of the symbol timing recovery loop with its configuration registers.
//
//  Channel   Direction  Handshake                     Payload
//  sample    in         sample_valid / sample_stall   sample_value
//  result    out        result_valid / result_stall   timing_offset, timing_phase, timing_error
//  config    in         APB write (psel, penable)     initial_phase @ 0x0, loop_gain @ 0x4
//
// A sample that completes no symbol is taken unless the queue is full or a symbol waits for
// its new phase. A sample that completes a symbol hands a job to the back end, which steps
// through the interpolants (sharing one multiplier), the error, the history, the magnitude,
// an eight-bit-a-cycle divider for the average, the sign, the gain and the phase update.
// Two more samples are taken meanwhile; the next one then stalls until the new phase returns.
// Reset clears counters, control state, configuration and error history at once; there is no
// clearing pass. A stalled result holds the back end in its last step, which stalls samples.

module symbol_timing_recovery_loop_top #(
    parameter int AVERAGE_LENGTH = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  strl_pkg::sample_t    sample_value,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    output strl_pkg::offset_t    timing_offset,
    output strl_pkg::phase_t     timing_phase,
    output strl_pkg::error_t     timing_error,
    output logic                 result_valid,
    input  logic                 result_stall
);

    strl_pkg::phase_t      initial_phase_reg, initial_phase_next;
    strl_pkg::gain_t       loop_gain_reg,     loop_gain_next;
    logic                  cfg_write;
    strl_pkg::phase_load_t phase_load;
    strl_pkg::commit_t     commit;
    logic                  q_push, q_ready, q_pop, q_valid;
    strl_pkg::job_t        push_job, pop_job;

    // The port is always ready; a write lands in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        initial_phase_next = initial_phase_reg;
        loop_gain_next     = loop_gain_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                strl_pkg::RegInitialPhase: initial_phase_next = pwdata[19:0];
                strl_pkg::RegLoopGain:     loop_gain_next     = pwdata[15:0];
                default:                   loop_gain_next     = loop_gain_reg;
            endcase
        end
    end

    // A write of the initial phase also reloads the running phase.
    assign phase_load.valid = cfg_write && (paddr[2] == strl_pkg::RegInitialPhase);
    assign phase_load.value = pwdata[19:0];

    always_comb
    begin
        case (paddr[2])
            strl_pkg::RegInitialPhase: prdata = 32'(initial_phase_reg);
            strl_pkg::RegLoopGain:     prdata = 32'(loop_gain_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_phase_reg <= strl_pkg::InitialPhaseReset;
            loop_gain_reg     <= strl_pkg::LoopGainReset;
        end
        else
        begin
            initial_phase_reg <= initial_phase_next;
            loop_gain_reg     <= loop_gain_next;
        end
    end

    // The front end counts samples, wraps the phase and spots the last sample of a symbol.
    strl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_value (sample_value),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .phase_load   (phase_load),
        .commit       (commit),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    // The queue carries a symbol's samples and wrapped timing to the back end.
    strl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_job  (pop_job)
    );

    // The back end computes the error and new phase and holds the result for transfer.
    strl_back #(
        .AVERAGE_LENGTH (AVERAGE_LENGTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_job         (pop_job),
        .q_pop         (q_pop),
        .loop_gain     (loop_gain_reg),
        .commit        (commit),
        .timing_offset (timing_offset),
        .timing_phase  (timing_phase),
        .timing_error  (timing_error),
        .result_valid  (result_valid),
        .result_stall  (result_stall)
    );

endmodule
